// ----- rtl/lps_pkg.sv -----
// Shared types and constants for the line pixel stepper.
// No dependencies; every other rtl file refers to this package by scoped names.
package lps_pkg;

    // Coordinate width and derived widths for deltas and the decision value
    localparam int COORD_W = 12;
    localparam int DELTA_W = COORD_W + 1;
    localparam int DEC_W   = COORD_W + 3;

    // Octant codes, octant one through eight
    typedef enum logic [2:0] {
        OCT_1 = 3'd0,
        OCT_2 = 3'd1,
        OCT_3 = 3'd2,
        OCT_4 = 3'd3,
        OCT_5 = 3'd4,
        OCT_6 = 3'd5,
        OCT_7 = 3'd6,
        OCT_8 = 3'd7
    } oct_t;

    // Command kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_NEXT  = 1'b1;

    // Input word
    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } cmd_word_t;

    // Result word
    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               last;
    } pix_word_t;

    // Line walking state, two's complement deltas and decision
    typedef struct packed {
        logic [COORD_W-1:0] cur_x;
        logic [COORD_W-1:0] cur_y;
        logic [COORD_W-1:0] major_end;
        logic [DELTA_W-1:0] delta_x;
        logic [DELTA_W-1:0] delta_y;
        logic [DEC_W-1:0]   decision;
        oct_t               octant;
    } lps_state_t;

endpackage

// ----- rtl/lps_setup.sv -----
// Line setup: deltas, octant choice and major endpoint from a start word.
// Depends on lps_pkg.
module lps_setup (
    input  lps_pkg::cmd_word_t  cmd,
    output lps_pkg::lps_state_t init
);

    localparam int SUM_W = lps_pkg::DELTA_W + 1;

    logic [lps_pkg::DELTA_W-1:0] dx;
    logic [lps_pkg::DELTA_W-1:0] dy;
    logic [SUM_W-1:0]            sum_d;
    logic [SUM_W-1:0]            diff_d;
    logic                        dx_neg;
    logic                        dy_neg;
    logic                        dx_zero;
    lps_pkg::oct_t               oct;
    logic                        x_major;

    // End minus start, one extra bit for the sign
    assign dx = {1'b0, cmd.end_x} - {1'b0, cmd.start_x};
    assign dy = {1'b0, cmd.end_y} - {1'b0, cmd.start_y};

    assign sum_d  = {dx[lps_pkg::DELTA_W-1], dx} + {dy[lps_pkg::DELTA_W-1], dy};
    assign diff_d = {dx[lps_pkg::DELTA_W-1], dx} - {dy[lps_pkg::DELTA_W-1], dy};

    assign dx_neg  = dx[lps_pkg::DELTA_W-1];
    assign dy_neg  = dy[lps_pkg::DELTA_W-1];
    assign dx_zero = (dx == '0);

    // Octant from delta signs and which delta dominates
    always_comb
    begin
        priority if (!dx_neg && !dy_neg)
        begin
            // dx > dy
            oct = (!diff_d[SUM_W-1] && (diff_d != '0)) ? lps_pkg::OCT_8 : lps_pkg::OCT_7;
        end
        else if (!dy_neg)
        begin
            // dx > -dy
            oct = (!sum_d[SUM_W-1] && (sum_d != '0)) ? lps_pkg::OCT_6 : lps_pkg::OCT_5;
        end
        else if (dx_neg || dx_zero)
        begin
            // dx < dy
            oct = diff_d[SUM_W-1] ? lps_pkg::OCT_4 : lps_pkg::OCT_3;
        end
        else
        begin
            // -dx > dy
            oct = sum_d[SUM_W-1] ? lps_pkg::OCT_2 : lps_pkg::OCT_1;
        end
    end

    assign x_major = (oct == lps_pkg::OCT_1) || (oct == lps_pkg::OCT_4) ||
                     (oct == lps_pkg::OCT_5) || (oct == lps_pkg::OCT_8);

    // Initial walking state
    always_comb
    begin
        init.cur_x     = cmd.start_x;
        init.cur_y     = cmd.start_y;
        init.major_end = x_major ? cmd.end_x : cmd.end_y;
        init.delta_x   = dx;
        init.delta_y   = dy;
        init.decision  = '0;
        init.octant    = oct;
    end

endmodule

// ----- rtl/lps_step.sv -----
// One pixel step: emits the current pixel and advances the walking state.
// Depends on lps_pkg.
module lps_step (
    input  lps_pkg::lps_state_t cur,
    output lps_pkg::lps_state_t nxt,
    output lps_pkg::pix_word_t  pix
);

    localparam int EXT_W = lps_pkg::DEC_W - lps_pkg::DELTA_W;

    logic [lps_pkg::DEC_W-1:0]   dxe;
    logic [lps_pkg::DEC_W-1:0]   dye;
    logic [lps_pkg::DEC_W-1:0]   plain;
    logic [lps_pkg::DEC_W-1:0]   taken;
    logic                        major_up;
    logic                        minor_up;
    logic                        pos_test;
    logic                        x_major;
    logic                        step;
    logic                        dec_neg;
    logic [lps_pkg::COORD_W-1:0] maj;
    logic [lps_pkg::COORD_W-1:0] maj_next;
    logic [lps_pkg::COORD_W-1:0] min_cur;
    logic [lps_pkg::COORD_W-1:0] min_next;
    logic                        last;

    assign dxe = {{EXT_W{cur.delta_x[lps_pkg::DELTA_W-1]}}, cur.delta_x};
    assign dye = {{EXT_W{cur.delta_y[lps_pkg::DELTA_W-1]}}, cur.delta_y};

    // Per-octant directions, sign test and decision increments
    always_comb
    begin
        unique case (cur.octant)
            lps_pkg::OCT_1:
            begin
                major_up = 1'b1; minor_up = 1'b0; pos_test = 1'b1; x_major = 1'b1;
                plain = -dye; taken = -dye - dxe;
            end
            lps_pkg::OCT_2:
            begin
                major_up = 1'b0; minor_up = 1'b1; pos_test = 1'b1; x_major = 1'b0;
                plain = dxe; taken = dxe + dye;
            end
            lps_pkg::OCT_3:
            begin
                major_up = 1'b0; minor_up = 1'b0; pos_test = 1'b0; x_major = 1'b0;
                plain = dxe; taken = dxe - dye;
            end
            lps_pkg::OCT_4:
            begin
                major_up = 1'b0; minor_up = 1'b0; pos_test = 1'b0; x_major = 1'b1;
                plain = dye; taken = dye - dxe;
            end
            lps_pkg::OCT_5:
            begin
                major_up = 1'b0; minor_up = 1'b1; pos_test = 1'b0; x_major = 1'b1;
                plain = -dye; taken = -dxe - dye;
            end
            lps_pkg::OCT_6:
            begin
                major_up = 1'b1; minor_up = 1'b0; pos_test = 1'b0; x_major = 1'b0;
                plain = dxe; taken = dxe + dye;
            end
            lps_pkg::OCT_7:
            begin
                major_up = 1'b1; minor_up = 1'b1; pos_test = 1'b1; x_major = 1'b0;
                plain = dxe; taken = dxe - dye;
            end
            default:
            begin
                major_up = 1'b1; minor_up = 1'b1; pos_test = 1'b1; x_major = 1'b1;
                plain = dye; taken = dye - dxe;
            end
        endcase
    end

    // Sign test on the decision value
    assign dec_neg = cur.decision[lps_pkg::DEC_W-1];
    assign step    = pos_test ? (!dec_neg && (cur.decision != '0)) : dec_neg;

    assign maj     = x_major ? cur.cur_x : cur.cur_y;
    assign min_cur = x_major ? cur.cur_y : cur.cur_x;
    assign last    = (maj == cur.major_end);

    // Major axis always moves, minor only on a taken step
    assign maj_next = major_up ? maj + 1'b1 : maj - 1'b1;
    always_comb
    begin
        if (step)
            min_next = minor_up ? min_cur + 1'b1 : min_cur - 1'b1;
        else
            min_next = min_cur;
    end

    // Next state; the last pixel leaves the walk where it is
    always_comb
    begin
        nxt = cur;
        if (!last)
        begin
            nxt.cur_x    = x_major ? maj_next : min_next;
            nxt.cur_y    = x_major ? min_next : maj_next;
            nxt.decision = cur.decision + (step ? taken : plain);
        end
    end

    assign pix.pixel_x = cur.cur_x;
    assign pix.pixel_y = cur.cur_y;
    assign pix.last    = last;

endmodule

// ----- rtl/line_pixel_stepper_core.sv -----
// Line pixel stepper top level: command intake, walking state and result register.
// Depends on lps_pkg, lps_setup and lps_step.
//
// A start word loads two endpoints and returns nothing; each next word then
// returns one pixel of the line, the final one flagged with last, after which
// the block is idle and ignores next words until the following start. A start
// word during a line drops that line. Setup or step logic sits between the
// walking-state registers and a single result register, so a new word is
// taken each cycle the result register is empty or being drained at the same
// edge, giving one pixel per clock at full rate.
module line_pixel_stepper_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  lps_pkg::cmd_word_t  cmd,
    output logic                pix_valid,
    input  logic                pix_stall,
    output lps_pkg::pix_word_t  pix
);

    lps_pkg::lps_state_t state_reg;
    lps_pkg::lps_state_t state_next;
    lps_pkg::lps_state_t init_state;
    lps_pkg::lps_state_t step_state;
    lps_pkg::pix_word_t  step_pix;
    lps_pkg::pix_word_t  pix_reg;
    lps_pkg::pix_word_t  pix_next;
    logic                busy_reg;
    logic                busy_next;
    logic                pix_valid_reg;
    logic                pix_valid_next;
    logic                accept;
    logic                is_start;
    logic                emit;

    lps_setup u_setup (
        .cmd  (cmd),
        .init (init_state)
    );

    lps_step u_step (
        .cur (state_reg),
        .nxt (step_state),
        .pix (step_pix)
    );

    // Hold the command side only while a result waits and is stalled
    assign cmd_stall = pix_valid_reg && pix_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign is_start  = (cmd.kind == lps_pkg::KIND_START);
    assign emit      = accept && !is_start && busy_reg;

    // Next walking state and busy flag
    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        if (accept && is_start)
        begin
            state_next = init_state;
            busy_next  = 1'b1;
        end
        else if (emit)
        begin
            state_next = step_state;
            busy_next  = !step_pix.last;
        end
    end

    // Result register
    always_comb
    begin
        pix_next = pix_reg;
        if (emit)
            pix_next = step_pix;
        if (emit)
            pix_valid_next = 1'b1;
        else if (pix_stall)
            pix_valid_next = pix_valid_reg;
        else
            pix_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pix_valid_reg <= 1'b0;
            state_reg     <= '0;
            pix_reg       <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pix_valid_reg <= pix_valid_next;
            state_reg     <= state_next;
            pix_reg       <= pix_next;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    // A start word makes the block busy and leaves no result behind
    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_start |=> busy_reg && !pix_valid_reg)
        else $error("start word did not load a fresh line");

    // A next word while idle produces nothing
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_start && !busy_reg |=> !pix_valid_reg && !busy_reg)
        else $error("next word while idle produced a result");

    // The final pixel ends the line and is flagged
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        emit && step_pix.last |=> !busy_reg && pix_valid_reg && pix_reg.last)
        else $error("last pixel did not end the line");

    // Any other pixel keeps the line going
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !step_pix.last |=> busy_reg && pix_valid_reg && !pix_reg.last)
        else $error("line ended before its last pixel");

endmodule
